// ===== design/rlm_pkg.sv =====
// rlm_pkg: shared widths, register indexes and constants of the rms level meter
// used by rms_level_meter and its port checker; no dependencies

package rlm_pkg;

  // stream payload widths
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 56;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_GAIN  = 2'd0,
    REG_RELEASE_GAIN = 2'd1,
    REG_FLOOR_DBFS   = 2'd2,
    REG_SPAN_DB      = 2'd3
  } cfg_reg_t;

  // register reset values
  localparam logic [15:0] ATTACK_GAIN_RST  = 16'd32768;
  localparam logic [15:0] RELEASE_GAIN_RST = 16'd6554;
  localparam logic [7:0]  FLOOR_DBFS_RST   = 8'hC4;  // -60
  localparam logic [6:0]  SPAN_DB_RST      = 7'd40;

  // block length default
  localparam int MAX_BLOCK_DEF = 256;

  // datapath widths
  localparam int SAMPLE_W   = 24;
  localparam int SUM_W      = 56;
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_W      = 22;
  localparam int DIV_W      = 24;
  localparam int DB_W       = 17;

  // 10*log10(2) in Q16 and the offset of 2^46 full scale in Q16 log2
  localparam logic [31:0] DB_PER_LOG2 = 32'd197283;
  localparam logic [23:0] LOG2_FS_OFS = 24'd3014656;
  localparam logic [15:0] DB_MIN_MAG  = 16'd36000;
  // -36000 in 17-bit two's complement
  localparam logic [DB_W-1:0] DB_MIN  = 17'h17360;

endpackage

// ===== design/rms_level_meter.sv =====
// rms_level_meter: block rms meter, dBFS in Q8.8, Q0.16 target and smoothing
// depends on rlm_pkg; one shared 32x32 multiplier under a one-hot sequencer
//
// Usage
//   s_* channel: one I2S slot word a transfer; s_tdata holds the slot with the
//   24-bit sample in bits 31..8, s_tlast marks the final sample of a block.
//   A block also ends when MAX_BLOCK samples have been summed.
//   m_* channel: one result a block; m_tdata holds level [15:0],
//   target_level [31:16] and block_dbfs [48:32].
//   cfg_*: write-only register port, taken at any edge with cfg_we high.
// Sequencing
//   s_tready is high only while the sequencer is idle. A sample that does not
//   end a block passes the transfer and then the square-and-add step.
//   A block end then normalizes the 56-bit sum by its leading zeros (one
//   normalize shift a cycle), forms its log2 fraction in 16 squaring steps,
//   does the same for the count, takes the log difference, scales it to dB,
//   forms the target in 24 divider steps (skipped when the level is at or
//   below the floor) and ends in the smoothing step. A silent block goes
//   straight to the smoothing step. Every product runs through one
//   multiplier.
// Reset and stall
//   rst clears the sum, count, smoothed level and registers to their defaults.
//   A result waits in the output register; the block keeps accepting samples,
//   and only holds in its last step if a new result is due while one waits.

module rms_level_meter #(
  parameter int MAX_BLOCK = rlm_pkg::MAX_BLOCK_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // slave stream: tdata = sample_word[31:0]
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rlm_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic                             s_tlast,
  // master stream: tdata = level[15:0], target_level[31:16], block_dbfs[48:32]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rlm_pkg::M_DATA_W-1:0]     m_tdata,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [rlm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rlm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import rlm_pkg::*;

  localparam int CW = $clog2(MAX_BLOCK + 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SQUARE = 9'b000000010,
    ST_NORM   = 9'b000000100,
    ST_LOGSQ  = 9'b000001000,
    ST_LDIFF  = 9'b000010000,
    ST_DBMUL  = 9'b000100000,
    ST_TGT    = 9'b001000000,
    ST_DIV    = 9'b010000000,
    ST_SMOOTH = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] attack_gain;
  logic [15:0] release_gain;
  logic [7:0]  floor_dbfs;
  logic [6:0]  span_db;

  // block state
  logic [SUM_W-1:0] square_sum;
  logic [CW-1:0]    sample_count;
  logic [15:0]      smoothed_level;

  // datapath registers
  logic [SAMPLE_W-1:0] mag;
  logic                last_r;
  logic [SUM_W-1:0]    nrm;
  logic [5:0]          expo;
  logic [31:0]         y;
  logic [LOG_FRAC_W-1:0] frac;
  logic                log_of_cnt;
  logic [LOG_W-1:0]    log_sum;
  logic [LOG_W-1:0]    log_cnt;
  logic [4:0]          itc;
  logic [21:0]         neg;
  logic [DB_W-1:0]     db;
  logic [15:0]         target;
  logic [DIV_W-1:0]    dvd;
  logic [6:0]          rem;
  logic [6:0]          dvsr;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  // combinational helpers
  logic [SAMPLE_W-1:0] top;
  logic [SAMPLE_W-1:0] mag_next;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_next;
  logic [CW-1:0]       count_next;
  logic                blk_end;
  logic                sq_hi;
  logic [31:0]         y_next;
  logic [LOG_FRAC_W-1:0] frac_next;
  logic [23:0]         l_val;
  logic [23:0]         neg_val;
  logic [39:0]         rnd;
  logic [15:0]         m_cl;
  logic [17:0]         diff;
  logic [7:0]          trial;
  logic [7:0]          trial_sub;
  logic                fits;
  logic                up;
  logic [15:0]         delta;
  logic [15:0]         gain;
  logic [15:0]         level_next;
  logic                out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // sample magnitude from the top 24 bits of the slot
  assign top      = s_tdata[31:8];
  assign mag_next = top[SAMPLE_W-1] ? (24'd0 - top) : top;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_SQUARE: begin
        mul_a = {8'h00, mag};
        mul_b = {8'h00, mag};
      end
      ST_LOGSQ: begin
        mul_a = y;
        mul_b = y;
      end
      ST_DBMUL: begin
        mul_a = {10'd0, neg};
        mul_b = DB_PER_LOG2;
      end
      ST_SMOOTH: begin
        mul_a = {16'd0, delta};
        mul_b = {16'd0, gain};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // saturating sum of squares and count
  assign sum_add    = {1'b0, square_sum} + {9'd0, mul_p[47:0]};
  assign sum_next   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign count_next = sample_count + 1'b1;
  assign blk_end    = last_r || (count_next == CW'(MAX_BLOCK));

  // one squaring step of the log2 fraction
  assign sq_hi     = mul_p[63];
  assign y_next    = sq_hi ? mul_p[63:32] : mul_p[62:31];
  assign frac_next = {frac[LOG_FRAC_W-2:0], sq_hi};

  // log2(sum) - log2(count) - 46, magnitude when negative
  assign l_val   = {2'b00, log_sum} - {2'b00, log_cnt} - LOG2_FS_OFS;
  assign neg_val = l_val[23] ? (24'd0 - l_val) : 24'd0;

  // dB scaling with round half up, clamped at the floor of the range
  assign rnd  = mul_p[39:0] + 40'h80_0000;
  assign m_cl = (rnd[39:24] > DB_MIN_MAG) ? DB_MIN_MAG : rnd[39:24];

  // distance above the floor
  assign diff = {db[DB_W-1], db} - {{2{floor_dbfs[7]}}, floor_dbfs, 8'h00};

  // restoring divider step
  assign trial     = {rem, dvd[DIV_W-1]};
  assign trial_sub = trial - {1'b0, dvsr};
  assign fits      = (trial >= {1'b0, dvsr});

  // attack/release smoothing
  assign up         = (target > smoothed_level);
  assign delta      = up ? (target - smoothed_level) : (smoothed_level - target);
  assign gain       = up ? attack_gain : release_gain;
  assign level_next = up ? (smoothed_level + mul_p[31:16])
                         : (smoothed_level - mul_p[31:16]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_gain  <= ATTACK_GAIN_RST;
      release_gain <= RELEASE_GAIN_RST;
      floor_dbfs   <= FLOOR_DBFS_RST;
      span_db      <= SPAN_DB_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ATTACK_GAIN:  attack_gain  <= cfg_wdata[15:0];
        REG_RELEASE_GAIN: release_gain <= cfg_wdata[15:0];
        REG_FLOOR_DBFS:   floor_dbfs   <= cfg_wdata[7:0];
        REG_SPAN_DB:      span_db      <= cfg_wdata[6:0];
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      square_sum     <= '0;
      sample_count   <= '0;
      smoothed_level <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(state == ST_SMOOTH && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          square_sum   <= sum_next;
          sample_count <= count_next;
          if (!blk_end) begin
            state <= ST_IDLE;
          end else if (sum_next == '0) begin
            state <= ST_SMOOTH;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (nrm[SUM_W-1]) begin
            state <= ST_LOGSQ;
          end
        end
        ST_LOGSQ: begin
          if (itc == 5'(LOG_FRAC_W - 1)) begin
            state <= log_of_cnt ? ST_LDIFF : ST_NORM;
          end
        end
        ST_LDIFF: state <= ST_DBMUL;
        ST_DBMUL: state <= ST_TGT;
        ST_TGT: begin
          if (diff[17] || diff == '0) begin
            state <= ST_SMOOTH;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (itc == 5'(DIV_W - 1)) begin
            state <= ST_SMOOTH;
          end
        end
        ST_SMOOTH: begin
          if (out_free) begin
            smoothed_level <= level_next;
            square_sum     <= '0;
            sample_count   <= '0;
            m_tvalid       <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        mag    <= mag_next;
        last_r <= s_tlast;
      end
      ST_SQUARE: begin
        // silent block result, or start the log of the sum
        db         <= DB_MIN;
        target     <= '0;
        nrm        <= sum_next;
        expo       <= 6'(SUM_W - 1);
        log_of_cnt <= 1'b0;
      end
      ST_NORM: begin
        if (nrm[SUM_W-1]) begin
          y    <= nrm[SUM_W-1 -: 32];
          frac <= '0;
          itc  <= '0;
        end else begin
          nrm  <= {nrm[SUM_W-2:0], 1'b0};
          expo <= expo - 1'b1;
        end
      end
      ST_LOGSQ: begin
        y    <= y_next;
        frac <= frac_next;
        itc  <= itc + 1'b1;
        if (itc == 5'(LOG_FRAC_W - 1)) begin
          if (log_of_cnt) begin
            log_cnt <= {expo, frac_next};
          end else begin
            log_sum    <= {expo, frac_next};
            nrm        <= {{(SUM_W-CW){1'b0}}, sample_count};
            expo       <= 6'(SUM_W - 1);
            log_of_cnt <= 1'b1;
          end
        end
      end
      ST_LDIFF: neg <= neg_val[21:0];
      ST_DBMUL: db  <= 17'd0 - {1'b0, m_cl};
      ST_TGT: begin
        target <= '0;
        dvd    <= {diff[15:0], 8'h00};
        rem    <= '0;
        dvsr   <= (span_db == '0) ? 7'd1 : span_db;
        itc    <= '0;
      end
      ST_DIV: begin
        rem <= fits ? trial_sub[6:0] : trial[6:0];
        dvd <= {dvd[DIV_W-2:0], fits};
        itc <= itc + 1'b1;
        if (itc == 5'(DIV_W - 1)) begin
          target <= (dvd[DIV_W-2:15] != '0) ? 16'hFFFF : {dvd[14:0], fits};
        end
      end
      ST_SMOOTH: begin
        if (out_free) begin
          m_tdata <= {7'd0, db, target, level_next};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/rlm_checker.sv =====
// rlm_checker: port-level assertions for rms_level_meter, bound to the top level
// depends on rlm_pkg for the stream widths and the dBFS floor

module rlm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [rlm_pkg::M_DATA_W-1:0] m_tdata
);

  import rlm_pkg::*;

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an accepted sample leaves the input not ready in the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    !rst && s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  // block level stays within -36000 .. 0
  a_db_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[48:32] == '0) ||
                 (m_tdata[48] && $signed(m_tdata[48:32]) >= $signed(DB_MIN)))
    else $error("block_dbfs out of range");

  // the lowest level always maps to a zero target
  a_floor_target: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[48:32] == DB_MIN |-> m_tdata[31:16] == '0)
    else $error("nonzero target at the lowest level");

  // a new result appears only at the end of a busy sequence
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without block processing");

endmodule

bind rms_level_meter rlm_checker u_rlm_checker (.*);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for rms_level_meter, the block rms dBFS meter
// depends on rlm_pkg and the rms_level_meter rtl; predicts each block result in place

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rlm_pkg::*;

  localparam int          BLOCK_LEN       = MAX_BLOCK_DEF;
  localparam logic [63:0] SUM_LIMIT       = (64'd1 << 56) - 64'd1;
  localparam longint      DB_PER_OCTAVE   = 197283;     // 10*log10(2) in Q16
  localparam longint      FULL_SCALE_LOG2 = 46 << 16;   // log2(2^46) in Q16
  localparam longint      DB_SAT_MAG      = 36000;
  localparam int          CFG_TAIL        = 20;
  localparam int          END_TAIL        = 250;

  // one block result as it leaves the meter
  typedef struct {
    logic [15:0] level;
    logic [15:0] target;
    logic [16:0] dbfs;
  } level_report_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;    // sample_word[31:0]
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;    // level[15:0], target_level[31:16], block_dbfs[48:32]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state and register copies
  logic [63:0]       square_acc;
  int                sample_total;
  logic [15:0]       level_reg;
  logic [15:0]       rise_gain;
  logic [15:0]       fall_gain;
  logic signed [7:0] floor_cfg;
  logic [6:0]        span_cfg;

  level_report_t pending_reports[$];
  level_report_t oldest_report;
  int            error_count = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;

  rms_level_meter #(.MAX_BLOCK(BLOCK_LEN)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // log2 in Q16 by normalize and repeated squaring, truncated
  function automatic logic [31:0] log2_fixed(input logic [63:0] v);
    int          e;
    logic [63:0] y;
    logic [15:0] frac;
    e = 63;
    while (e > 0 && !v[e]) e--;
    y = (v << (63 - e)) >> 32;
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return {e[15:0], frac};
  endfunction

  // accumulate one accepted sample, queue the block result at block end
  task automatic meter_accept_sample(input logic [31:0] word, input logic last);
    logic [23:0]   pcm;
    logic [63:0]   mag;
    logic [63:0]   sq;
    longint        lg;
    longint        neg;
    longint        mag_db;
    int            db;
    int            diff;
    int            span_eff;
    int            scaled;
    int unsigned   tgt;
    int unsigned   lvl;
    logic [15:0]   target;
    level_report_t rpt;
    pcm = word[31:8];
    mag = pcm[23] ? (64'h100_0000 - 64'(pcm)) : 64'(pcm);
    sq = mag * mag;
    if (square_acc > SUM_LIMIT - sq) square_acc = SUM_LIMIT;
    else square_acc = square_acc + sq;
    sample_total++;
    if (!last && sample_total < BLOCK_LEN) return;

    // block level and target
    if (square_acc == 0) begin
      db = -int'(DB_SAT_MAG);
      target = '0;
    end else begin
      lg = longint'(log2_fixed(square_acc)) - longint'(log2_fixed(64'(sample_total)))
           - FULL_SCALE_LOG2;
      neg = (lg < 0) ? -lg : 0;
      mag_db = (neg * DB_PER_OCTAVE + (64'sd1 <<< 23)) >>> 24;
      if (mag_db > DB_SAT_MAG) mag_db = DB_SAT_MAG;
      db = -int'(mag_db);
      span_eff = (span_cfg == 0) ? 1 : int'(span_cfg);
      diff = db - int'(floor_cfg) * 256;
      if (diff <= 0) begin
        target = '0;
      end else begin
        scaled = (diff * 256) / span_eff;
        target = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
      end
    end

    // attack or release smoothing
    tgt = target;
    lvl = level_reg;
    if (tgt > lvl) lvl = lvl + (((tgt - lvl) * rise_gain) >> 16);
    else lvl = lvl - (((lvl - tgt) * fall_gain) >> 16);
    level_reg = lvl[15:0];

    square_acc = '0;
    sample_total = 0;
    rpt.level = level_reg;
    rpt.target = target;
    rpt.dbfs = 17'(db);
    pending_reports.push_back(rpt);
  endtask

  // one register write while the meter is idle
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_ATTACK_GAIN:  rise_gain = data;
      REG_RELEASE_GAIN: fall_gain = data;
      REG_FLOOR_DBFS:   floor_cfg = data[7:0];
      REG_SPAN_DB:      span_cfg = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [15:0] att, input logic [15:0] rel,
                                input logic [7:0] flr, input logic [6:0] spn);
    write_reg(REG_ATTACK_GAIN, att);
    write_reg(REG_RELEASE_GAIN, rel);
    write_reg(REG_FLOOR_DBFS, {8'($urandom_range(0, 255)), flr});
    write_reg(REG_SPAN_DB, {9'($urandom_range(0, 511)), spn});
  endtask

  // send one sample word, with random sender gaps
  task automatic send_sample(input logic [31:0] word, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    meter_accept_sample(word, last);
  endtask

  // samples at one amplitude, bar rare full-scale words; a shift of 32 or more sends silence
  task automatic send_block(input int len, input int shift, input bit mark_last);
    logic [31:0] word;
    for (int i = 0; i < len; i++) begin
      if (shift >= 32) word = 32'($urandom_range(0, 255));
      else word = $signed($urandom) >>> shift;
      if ($urandom_range(0, 19) == 0)
        word = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FF00)
               | 32'($urandom_range(0, 255));
      send_sample(word, (i == len - 1) ? mark_last : 1'b0);
    end
  endtask

  // drop valid and wait for every queued result, then let the block settle
  task automatic quiesce(input int tail);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, expected none, actual %h", $time, m_tdata);
      end else begin
        oldest_report = pending_reports.pop_front();
        compare_field("level", oldest_report.level, m_tdata[15:0]);
        compare_field("target_level", oldest_report.target, m_tdata[31:16]);
        compare_field("block_dbfs", $signed(oldest_report.dbfs), $signed(m_tdata[48:32]));
      end
    end
  end

  // sample extremes under the reset register values
  task automatic test_level_extremes();
    // silent block, low byte ignored
    send_sample(32'h0000_00FF, 1'b0);
    send_sample(32'h0000_0055, 1'b1);
    // full scale, both signs
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    // very quiet block saturates the dBFS floor
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    // single lsb sample, just above saturation
    send_sample(32'h0000_0100, 1'b1);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'hEDCB_A987, 1'b1);
    quiesce(CFG_TAIL);
  endtask

  // register extremes, zero span and a positive floor
  task automatic test_register_extremes();
    write_all_regs(16'hFFFF, 16'hFFFF, 8'h88, 7'd120);
    send_sample(32'h8000_0000, 1'b1);
    send_block(2, $urandom_range(0, 12), 1'b1);
    quiesce(CFG_TAIL);
    write_all_regs(16'h0000, 16'h0000, 8'h00, 7'd1);
    send_sample(32'h8000_0000, 1'b1);
    send_block(2, $urandom_range(0, 12), 1'b1);
    quiesce(CFG_TAIL);
    write_all_regs(16'h0001, 16'h8000, 8'h7F, 7'd0);
    send_sample(32'h8000_0000, 1'b1);
    send_block(2, $urandom_range(0, 12), 1'b1);
    quiesce(CFG_TAIL);
    write_all_regs(16'($urandom), 16'($urandom), 8'h80, 7'd127);
    send_sample(32'h8000_0000, 1'b1);
    send_block(2, $urandom_range(0, 12), 1'b1);
    quiesce(CFG_TAIL);
  endtask

  // block closed by the sample count, then one closed by last on the same count
  task automatic test_max_block_length();
    write_all_regs(16'd32768, 16'd6554, 8'hC4, 7'd40);
    send_block(BLOCK_LEN, $urandom_range(0, 20), 1'b0);
    send_block(BLOCK_LEN, $urandom_range(0, 20), 1'b1);
    quiesce(CFG_TAIL);
  endtask

  // random blocks over several register settings and idling patterns
  task automatic test_random_blocks();
    int sent;
    int len;
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 45; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 45; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      if (phase == 4) write_all_regs(16'hFFFF, 16'h0001, 8'h88, 7'd1);
      else write_all_regs(16'($urandom), 16'($urandom),
                          8'(-int'($urandom_range(0, 120))), 7'($urandom_range(1, 120)));
      sent = 0;
      while (sent < 140) begin
        pick = $urandom_range(0, 99);
        if (pick < 1) len = BLOCK_LEN;
        else if (pick < 5) len = $urandom_range(20, 60);
        else len = $urandom_range(1, 10);
        send_block(len, $urandom_range(0, 34),
                   (len == BLOCK_LEN) ? 1'($urandom_range(0, 1)) : 1'b1);
        sent += len;
      end
      quiesce((phase == 7) ? END_TAIL : CFG_TAIL);
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ATTACK_GAIN;
    cfg_wdata = '0;
    square_acc = '0;
    sample_total = 0;
    level_reg = '0;
    rise_gain = ATTACK_GAIN_RST;
    fall_gain = RELEASE_GAIN_RST;
    floor_cfg = FLOOR_DBFS_RST;
    span_cfg = SPAN_DB_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_level_extremes();
    test_register_extremes();
    test_max_block_length();
    test_random_blocks();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
